// ===== hw/rtl/mused_pkg.sv =====
package mused_pkg;

  // Parser phase of the front end
  typedef enum logic [1:0] {
    PH_STATUS,
    PH_FLAG,
    PH_DUR,
    PH_ARGS
  } phase_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_FIN,
    BK_OUT
  } back_state_t;

  // Event kinds
  localparam logic [3:0] KIND_NOTE    = 4'd0;
  localparam logic [3:0] KIND_WAIT    = 4'd1;
  localparam logic [3:0] KIND_TEMPO   = 4'd2;
  localparam logic [3:0] KIND_PROGRAM = 4'd3;
  localparam logic [3:0] KIND_VOLUME  = 4'd4;
  localparam logic [3:0] KIND_EXPR    = 4'd5;
  localparam logic [3:0] KIND_PAN     = 4'd6;
  localparam logic [3:0] KIND_END     = 4'd7;
  localparam logic [3:0] KIND_OTHER   = 4'd8;
  localparam logic [3:0] KIND_UNKNOWN = 4'd9;

  // Opcodes with side effects
  localparam logic [7:0] OP_WAIT_REP   = 8'h90;
  localparam logic [7:0] OP_WAIT_DELTA = 8'h91;
  localparam logic [7:0] OP_WAIT8      = 8'h92;
  localparam logic [7:0] OP_WAIT16     = 8'h93;
  localparam logic [7:0] OP_WAIT24     = 8'h94;
  localparam logic [7:0] OP_END        = 8'h98;
  localparam logic [7:0] OP_OCT_SET    = 8'hA0;
  localparam logic [7:0] OP_OCT_ADD    = 8'hA1;
  localparam logic [7:0] OP_SCALE      = 8'hBC;

  // Reciprocal of 127 used for duration scaling
  localparam logic [25:0] RECIP_127      = 26'h2040811;
  localparam logic [25:0] WAIT_MAX       = 26'h3FFFFFF;
  localparam logic [23:0] NOTE_LEN_RESET = 24'd48;
  localparam logic [7:0]  SCALE_RESET    = 8'd127;
  localparam logic [7:0]  OCTAVE_RESET   = 8'd4;

  // Event queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [2:0] nargs;
    logic [3:0] kind;
  } op_info_t;

  // Decoded event handed from the front to the back
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  status;
    logic [7:0]  key;
    logic [6:0]  vel;
    logic [25:0] ticks;   // raw duration for notes, wait length otherwise
    logic [7:0]  scale;
    logic [7:0]  arg;
    logic [31:0] offset;
    logic [2:0]  nbytes;
    logic [31:0] etime;
  } ev_t;

  // Short-wait table
  function automatic logic [7:0] wait_len(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'h0: r = 8'd96;
      4'h1: r = 8'd72;
      4'h2: r = 8'd64;
      4'h3: r = 8'd48;
      4'h4: r = 8'd36;
      4'h5: r = 8'd32;
      4'h6: r = 8'd24;
      4'h7: r = 8'd18;
      4'h8: r = 8'd16;
      4'h9: r = 8'd12;
      4'hA: r = 8'd9;
      4'hB: r = 8'd8;
      4'hC: r = 8'd6;
      4'hD: r = 8'd4;
      4'hE: r = 8'd3;
      4'hF: r = 8'd2;
    endcase
    return r;
  endfunction

  // Argument count and kind of a control opcode
  function automatic op_info_t op_info(input logic [7:0] op);
    op_info_t r;
    r.kind = KIND_OTHER;
    r.nargs = 3'd0;
    case (op)
      8'h90: begin r.kind = KIND_WAIT; r.nargs = 3'd0; end
      8'h91, 8'h92: begin r.kind = KIND_WAIT; r.nargs = 3'd1; end
      8'h93: begin r.kind = KIND_WAIT; r.nargs = 3'd2; end
      8'h94: begin r.kind = KIND_WAIT; r.nargs = 3'd3; end
      8'h98: begin r.kind = KIND_END; r.nargs = 3'd0; end
      8'hA4, 8'hA5: begin r.kind = KIND_TEMPO; r.nargs = 3'd1; end
      8'hAC: begin r.kind = KIND_PROGRAM; r.nargs = 3'd1; end
      8'hE0: begin r.kind = KIND_VOLUME; r.nargs = 3'd1; end
      8'hE3: begin r.kind = KIND_EXPR; r.nargs = 3'd1; end
      8'hE8: begin r.kind = KIND_PAN; r.nargs = 3'd1; end
      8'h99, 8'h9D, 8'h9E, 8'hB0, 8'hC0: r.nargs = 3'd0;
      8'h95, 8'h9C, 8'hA0, 8'hA1, 8'hA9, 8'hAA, 8'hAB, 8'hB1, 8'hB2, 8'hB3,
      8'hB5, 8'hB6, 8'hBC, 8'hBE, 8'hBF, 8'hC3, 8'hD0, 8'hD1, 8'hD2, 8'hDB,
      8'hDF, 8'hE7, 8'hEF, 8'hE1, 8'hE9, 8'hF6: r.nargs = 3'd1;
      8'hA8, 8'hB4, 8'hCB, 8'hD3, 8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hF2,
      8'hF8: r.nargs = 3'd2;
      8'hAF, 8'hD4, 8'hE2, 8'hEA, 8'hF3: r.nargs = 3'd3;
      8'hDD, 8'hE5, 8'hED, 8'hF1: r.nargs = 3'd4;
      8'hDC, 8'hE4, 8'hEC, 8'hF0: r.nargs = 3'd5;
      default: r.kind = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/mused_front.sv =====
module mused_front #(
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_fire,
  input  logic [7:0]       in_byte,
  output logic             ev_push,
  output mused_pkg::ev_t   ev
);
  import mused_pkg::*;

  phase_t                 phase, phase_next;
  logic [7:0]             pending_status, pending_status_next;
  logic [2:0]             bytes_left, bytes_left_next;
  logic [23:0]            arg_accum, arg_accum_next;
  logic [3:0]             note_idx, note_idx_next;
  logic [7:0]             octave_now, octave_now_next;
  logic [23:0]            last_note_len, last_note_len_next;
  logic [25:0]            last_wait_len, last_wait_len_next;
  logic [7:0]             length_scale, length_scale_next;
  logic [TIME_BITS-1:0]   tick_clock, tick_clock_next;
  logic [31:0]            byte_position, byte_position_next;
  logic [31:0]            event_start, event_start_next;
  logic                   track_ended, track_ended_next;

  // Combinational decode scratch
  logic        do_op, do_note, do_tab;
  logic [7:0]  op_sel, a;
  logic [23:0] acc_sel, dur_sel;
  logic [3:0]  idx_sel;
  op_info_t    info;
  logic [2:0]  pos;
  logic [27:0] delta_sum;
  logic [25:0] f_ticks;
  logic [3:0]  f_kind;
  logic [7:0]  f_arg;
  logic [63:0] ticks_wide, clock_wide;

  // Byte parser
  always_comb begin
    phase_next = phase;
    pending_status_next = pending_status;
    bytes_left_next = bytes_left;
    arg_accum_next = arg_accum;
    note_idx_next = note_idx;
    octave_now_next = octave_now;
    last_note_len_next = last_note_len;
    last_wait_len_next = last_wait_len;
    length_scale_next = length_scale;
    tick_clock_next = tick_clock;
    byte_position_next = byte_position;
    event_start_next = event_start;
    track_ended_next = track_ended;
    do_op = 1'b0;
    do_note = 1'b0;
    do_tab = 1'b0;
    op_sel = pending_status;
    acc_sel = 24'd0;
    dur_sel = last_note_len;
    idx_sel = note_idx;
    pos = 3'd0;
    info = op_info(pending_status);
    if (byte_fire && !track_ended) begin
      byte_position_next = byte_position + 32'd1;
      unique case (phase)
        PH_STATUS: begin
          event_start_next = byte_position;
          pending_status_next = in_byte;
          arg_accum_next = 24'd0;
          op_sel = in_byte;
          info = op_info(in_byte);
          if (!in_byte[7]) begin
            phase_next = PH_FLAG;
          end else if (in_byte[7:4] == 4'h8) begin
            do_tab = 1'b1;
          end else if (info.nargs == 3'd0) begin
            do_op = 1'b1;
          end else begin
            bytes_left_next = info.nargs;
            phase_next = PH_ARGS;
          end
        end
        PH_FLAG: begin
          octave_now_next = octave_now + {6'd0, in_byte[5:4]} + 8'd254;
          note_idx_next = in_byte[3:0];
          idx_sel = in_byte[3:0];
          arg_accum_next = 24'd0;
          if (in_byte[7:6] == 2'd0) begin
            do_note = 1'b1;
          end else begin
            bytes_left_next = {1'b0, in_byte[7:6]};
            phase_next = PH_DUR;
          end
        end
        PH_DUR: begin
          dur_sel = {arg_accum[15:0], in_byte};
          arg_accum_next = dur_sel;
          bytes_left_next = bytes_left - 3'd1;
          if (bytes_left == 3'd1) begin
            last_note_len_next = dur_sel;
            do_note = 1'b1;
          end
        end
        PH_ARGS: begin
          pos = info.nargs - bytes_left;
          acc_sel = arg_accum;
          unique case (pos)
            3'd0: acc_sel[7:0] = in_byte;
            3'd1: acc_sel[15:8] = in_byte;
            3'd2: acc_sel[23:16] = in_byte;
            default: ;
          endcase
          arg_accum_next = acc_sel;
          bytes_left_next = bytes_left - 3'd1;
          if (bytes_left == 3'd1) do_op = 1'b1;
        end
      endcase
    end

    // Event completion
    a = acc_sel[7:0];
    f_ticks = 26'd0;
    f_kind = info.kind;
    f_arg = 8'd0;
    delta_sum = {2'b00, last_wait_len} + {{20{a[7]}}, a};
    if (do_tab) begin
      f_kind = KIND_WAIT;
      f_ticks = {18'd0, wait_len(in_byte[3:0])};
      last_wait_len_next = f_ticks;
    end else if (do_note) begin
      f_kind = KIND_NOTE;
      f_ticks = {2'b00, dur_sel};
    end else if (do_op) begin
      case (op_sel)
        OP_WAIT_REP: f_ticks = last_wait_len;
        OP_WAIT_DELTA: begin
          if (delta_sum[27]) f_ticks = 26'd0;
          else if (delta_sum[26]) f_ticks = WAIT_MAX;
          else f_ticks = delta_sum[25:0];
          last_wait_len_next = f_ticks;
        end
        OP_WAIT8, OP_WAIT16, OP_WAIT24: begin
          f_ticks = {2'b00, acc_sel};
          last_wait_len_next = f_ticks;
        end
        OP_END: track_ended_next = 1'b1;
        OP_OCT_SET: octave_now_next = a;
        OP_OCT_ADD: octave_now_next = octave_now + a;
        OP_SCALE: length_scale_next = a;
        default: ;
      endcase
      if (info.kind >= KIND_TEMPO && info.kind <= KIND_PAN) f_arg = a;
    end
    ticks_wide = 64'(f_ticks);
    if (do_tab || do_op) tick_clock_next = tick_clock + ticks_wide[TIME_BITS-1:0];
  end

  // Event record
  always_comb begin
    clock_wide = 64'(tick_clock);
    ev_push = do_tab || do_note || do_op;
    ev.kind = f_kind;
    ev.status = pending_status_next;
    ev.key = do_note ? 8'(octave_now_next * 8'd12 + {4'd0, idx_sel}) : 8'd0;
    ev.vel = do_note ? pending_status_next[6:0] : 7'd0;
    ev.ticks = f_ticks;
    ev.scale = length_scale;
    ev.arg = f_arg;
    ev.offset = event_start_next;
    ev.nbytes = 3'(byte_position - event_start_next + 32'd1);
    ev.etime = clock_wide[31:0];
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_STATUS;
      pending_status <= 8'd0;
      bytes_left <= 3'd0;
      arg_accum <= 24'd0;
      note_idx <= 4'd0;
      octave_now <= OCTAVE_RESET;
      last_note_len <= NOTE_LEN_RESET;
      last_wait_len <= 26'd0;
      length_scale <= SCALE_RESET;
      tick_clock <= '0;
      byte_position <= 32'd0;
      event_start <= 32'd0;
      track_ended <= 1'b0;
    end else begin
      phase <= ev_push ? PH_STATUS : phase_next;
      pending_status <= pending_status_next;
      bytes_left <= ev_push ? 3'd0 : bytes_left_next;
      arg_accum <= arg_accum_next;
      note_idx <= note_idx_next;
      octave_now <= octave_now_next;
      last_note_len <= last_note_len_next;
      last_wait_len <= last_wait_len_next;
      length_scale <= length_scale_next;
      tick_clock <= tick_clock_next;
      byte_position <= byte_position_next;
      event_start <= event_start_next;
      track_ended <= track_ended_next;
    end
  end

`ifndef SYNTHESIS
  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    track_ended |=> track_ended) else $error("end flag cleared");
  a_mid_event_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DUR || phase == PH_ARGS) |-> bytes_left != 3'd0)
    else $error("argument phase with no bytes left");
  a_no_push_after_end: assert property (@(posedge clk) disable iff (rst)
    track_ended |-> !ev_push) else $error("event after end");
`endif

endmodule

// ===== hw/rtl/mused_queue.sv =====
module mused_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mused_pkg::ev_t push_ev,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output mused_pkg::ev_t pop_ev
);
  import mused_pkg::*;

  ev_t                mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full = (count == QCNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign pop_ev = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_ev;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid) else $error("queue underflow");
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("count mismatch");
`endif

endmodule

// ===== hw/rtl/mused_back.sv =====
module mused_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mused_pkg::ev_t q_ev,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     event_kind,
  output logic [7:0]     status_code,
  output logic [7:0]     note_key,
  output logic [6:0]     note_velocity,
  output logic [25:0]    ticks,
  output logic [7:0]     arg_value,
  output logic [31:0]    event_offset,
  output logic [2:0]     event_bytes,
  output logic [31:0]    event_time
);
  import mused_pkg::*;

  back_state_t state, state_next;
  ev_t         rec;
  logic [31:0] prod;
  logic [31:0] hi;
  logic [57:0] recip_prod;
  logic [31:0] fin_sum;
  logic [25:0] out_ticks;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_MUL1;
      BK_MUL1: state_next = BK_MUL2;
      BK_MUL2: state_next = BK_FIN;
      BK_FIN:  state_next = BK_OUT;
      BK_OUT:  if (out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    q_pop = (state == BK_IDLE) && q_valid;
    out_valid = (state == BK_OUT);
  end

  // Scale arithmetic: len * scale / 127 through the reciprocal
  assign recip_prod = 58'(prod) * 58'(RECIP_127);
  assign fin_sum = hi + ((prod - hi) >> 1);

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) rec <= q_ev;
    if (state == BK_MUL1) prod <= {8'd0, rec.ticks[23:0]} * {24'd0, rec.scale};
    if (state == BK_MUL2) hi <= {6'd0, recip_prod[57:32]};
    if (state == BK_FIN) out_ticks <= (rec.kind == KIND_NOTE) ? fin_sum[31:6] : rec.ticks;
  end

  assign event_kind = rec.kind;
  assign status_code = rec.status;
  assign note_key = rec.key;
  assign note_velocity = rec.vel;
  assign ticks = out_ticks;
  assign arg_value = rec.arg;
  assign event_offset = rec.offset;
  assign event_bytes = rec.nbytes;
  assign event_time = rec.etime;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == BK_IDLE) else $error("pop outside idle");
  a_fin_to_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == BK_FIN) else $error("result skipped scaling");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    state == BK_OUT && !out_ready |=> state == BK_OUT) else $error("result dropped");
`endif

endmodule

// ===== hw/rtl/music_sequence_event_decoder.sv =====
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | in_byte
// output   | out_valid / out_ready| event_kind .. event_time
//
// One byte is parsed per clock; in_ready drops only while the 4-entry event
// queue is full. Each event passes in order through the back-end states (pop,
// two multiply stages for the duration scale, final add, output); the next
// is popped once the result is taken. Reset (rst, synchronous) returns the
// parser to its power-on state and empties the queue; a stalled result holds.
module music_sequence_event_decoder #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_kind,
  output logic [7:0]  status_code,
  output logic [7:0]  note_key,
  output logic [6:0]  note_velocity,
  output logic [25:0] ticks,
  output logic [7:0]  arg_value,
  output logic [31:0] event_offset,
  output logic [2:0]  event_bytes,
  output logic [31:0] event_time
);
  import mused_pkg::*;

  logic ev_push, q_full, q_pop, q_valid;
  ev_t  push_ev, pop_ev;

  assign in_ready = !q_full;

  // Parser
  mused_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_fire (in_valid && in_ready),
    .in_byte   (in_byte),
    .ev_push   (ev_push),
    .ev        (push_ev)
  );

  // Event queue
  mused_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (ev_push),
    .push_ev (push_ev),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_ev  (pop_ev)
  );

  // Duration scaling and result register
  mused_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ev          (pop_ev),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .status_code   (status_code),
    .note_key      (note_key),
    .note_velocity (note_velocity),
    .ticks         (ticks),
    .arg_value     (arg_value),
    .event_offset  (event_offset),
    .event_bytes   (event_bytes),
    .event_time    (event_time)
  );

endmodule

// ===== sim/music_sequence_event_decoder_tb.sv =====
module music_sequence_event_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mused_pkg::*;

  // Control opcodes used by the directed sequence
  localparam logic [7:0] OP_TEMPO   = 8'hA4;
  localparam logic [7:0] OP_PROGRAM = 8'hAC;
  localparam logic [7:0] OP_VOLUME  = 8'hE0;
  localparam logic [7:0] OP_EXPR    = 8'hE3;
  localparam logic [7:0] OP_PAN     = 8'hE8;
  localparam logic [7:0] OP_FADE    = 8'h95;
  localparam logic [7:0] OP_SKIP5   = 8'hDC;
  localparam logic [7:0] OP_SKIP0   = 8'h99;
  localparam logic [7:0] OP_UNDEF   = 8'hFF;
  localparam logic [7:0] WAIT_SHORT = 8'h80;

  typedef enum logic [1:0] {P_STATUS, P_FLAG, P_DUR, P_ARGS} parse_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  status;
    logic [7:0]  key;
    logic [6:0]  vel;
    logic [25:0] ticks;
    logic [7:0]  arg;
    logic [31:0] offset;
    logic [2:0]  nbytes;
    logic [31:0] etime;
  } event_t;

  // Argument byte count and kind of a control opcode
  function automatic int opcode_args(input logic [7:0] op, output logic [3:0] kind);
    kind = KIND_OTHER;
    case (op)
      8'h90: begin kind = KIND_WAIT; return 0; end
      8'h91, 8'h92: begin kind = KIND_WAIT; return 1; end
      8'h93: begin kind = KIND_WAIT; return 2; end
      8'h94: begin kind = KIND_WAIT; return 3; end
      8'h98: begin kind = KIND_END; return 0; end
      8'hA4, 8'hA5: begin kind = KIND_TEMPO; return 1; end
      8'hAC: begin kind = KIND_PROGRAM; return 1; end
      8'hE0: begin kind = KIND_VOLUME; return 1; end
      8'hE3: begin kind = KIND_EXPR; return 1; end
      8'hE8: begin kind = KIND_PAN; return 1; end
      8'h99, 8'h9D, 8'h9E, 8'hB0, 8'hC0: return 0;
      8'h95, 8'h9C, 8'hA0, 8'hA1, 8'hA9, 8'hAA, 8'hAB, 8'hB1, 8'hB2, 8'hB3,
      8'hB5, 8'hB6, 8'hBC, 8'hBE, 8'hBF, 8'hC3, 8'hD0, 8'hD1, 8'hD2, 8'hDB,
      8'hDF, 8'hE7, 8'hEF, 8'hE1, 8'hE9, 8'hF6: return 1;
      8'hA8, 8'hB4, 8'hCB, 8'hD3, 8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hF2,
      8'hF8: return 2;
      8'hAF, 8'hD4, 8'hE2, 8'hEA, 8'hF3: return 3;
      8'hDD, 8'hE5, 8'hED, 8'hF1: return 4;
      8'hDC, 8'hE4, 8'hEC, 8'hF0: return 5;
      default: begin kind = KIND_UNKNOWN; return 0; end
    endcase
  endfunction

  class event_scoreboard;
    event_t      pending_events[$];
    int          errors;
    parse_t      phase;
    logic [7:0]  status;
    int          left;
    logic [23:0] accum;
    logic [3:0]  note_idx;
    logic [7:0]  octave;
    logic [23:0] note_len;
    logic [25:0] wait_len;
    logic [7:0]  len_scale;
    logic [31:0] tick_clk;
    logic [31:0] position;
    logic [31:0] start_pos;
    bit          ended;

    function new();
      phase = P_STATUS; status = 0; left = 0; accum = 0; note_idx = 0;
      octave = 4; note_len = 48; wait_len = 0; len_scale = 127;
      tick_clk = 0; position = 0; start_pos = 0; ended = 0; errors = 0;
    endfunction

    // dur * scale / 127 by reciprocal multiply
    function logic [25:0] scaled_len(input logic [23:0] dur);
      logic [31:0] prod;
      logic [63:0] wide;
      logic [31:0] hi;
      logic [31:0] diff;
      logic [31:0] r;
      prod = 32'(dur) * 32'(len_scale);
      wide = 64'(prod) * 64'h02040811;
      hi = wide[63:32];
      diff = prod - hi;
      r = (hi + (diff >> 1)) >> 6;
      return r[25:0];
    endfunction

    function void push_event(logic [3:0] kind, logic [7:0] key, logic [6:0] vel,
                             logic [25:0] t, logic [7:0] arg);
      event_t e;
      logic [31:0] span;
      span = position - start_pos + 1;
      e.kind = kind; e.status = status; e.key = key; e.vel = vel; e.ticks = t;
      e.arg = arg; e.offset = start_pos; e.nbytes = span[2:0]; e.etime = tick_clk;
      pending_events.push_back(e);
      phase = P_STATUS;
      left = 0;
    endfunction

    function void finish_note(logic [23:0] dur);
      logic [7:0] key;
      key = octave * 8'd12 + 8'(note_idx);
      push_event(KIND_NOTE, key, status[6:0], scaled_len(dur), 8'd0);
    endfunction

    function void finish_op();
      logic [3:0]  kind;
      logic [7:0]  a;
      logic [25:0] t;
      int          v;
      void'(opcode_args(status, kind));
      a = accum[7:0];
      t = 0;
      case (status)
        OP_WAIT_REP: t = wait_len;
        OP_WAIT_DELTA: begin
          v = int'(wait_len) + int'($signed(a));
          if (v < 0) v = 0;
          if (v > int'(WAIT_MAX)) v = int'(WAIT_MAX);
          wait_len = v[25:0];
          t = wait_len;
        end
        OP_WAIT8, OP_WAIT16, OP_WAIT24: begin
          wait_len = 26'(accum);
          t = wait_len;
        end
        OP_END: ended = 1;
        OP_OCT_SET: octave = a;
        OP_OCT_ADD: octave = octave + a;
        OP_SCALE: len_scale = a;
        default: ;
      endcase
      push_event(kind, 8'd0, 7'd0, t,
                 (kind >= KIND_TEMPO && kind <= KIND_PAN) ? a : 8'd0);
      tick_clk = tick_clk + 32'(t);
    endfunction

    // Advance the parser by one accepted byte
    function void note_byte(logic [7:0] b);
      logic [3:0] kind;
      logic [7:0] t;
      int n;
      if (ended) return;
      case (phase)
        P_STATUS: begin
          start_pos = position; status = b; accum = 0;
          if (b <= 8'h7F) phase = P_FLAG;
          else if (b <= 8'h8F) begin
            case (b[3:0])
              0: t = 96;  1: t = 72;  2: t = 64;  3: t = 48;
              4: t = 36;  5: t = 32;  6: t = 24;  7: t = 18;
              8: t = 16;  9: t = 12;  10: t = 9;  11: t = 8;
              12: t = 6;  13: t = 4;  14: t = 3;  default: t = 2;
            endcase
            wait_len = 26'(t);
            push_event(KIND_WAIT, 8'd0, 7'd0, 26'(t), 8'd0);
            tick_clk = tick_clk + 32'(t);
          end else begin
            n = opcode_args(b, kind);
            if (n == 0) finish_op();
            else begin left = n; phase = P_ARGS; end
          end
        end
        P_FLAG: begin
          octave = octave + 8'(b[5:4]) + 8'd254;
          note_idx = b[3:0];
          if (b[7:6] == 0) finish_note(note_len);
          else begin left = b[7:6]; accum = 0; phase = P_DUR; end
        end
        P_DUR: begin
          accum = {accum[15:0], b};
          left--;
          if (left == 0) begin note_len = accum; finish_note(accum); end
        end
        default: begin
          n = opcode_args(status, kind) - left;
          if (n < 3) accum = accum | (24'(b) << (8 * n));
          left--;
          if (left == 0) finish_op();
        end
      endcase
      position++;
    endfunction

    function void check_event(event_t got);
      event_t e;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected event: kind %0d status %h at %0t",
                                   got.kind, got.status, $realtime);
        return;
      end
      e = pending_events.pop_front();
      if (got != e) begin
        errors++;
        if (errors <= 10) begin
          $display("event mismatch at %0t", $realtime);
          $display("  exp kind %0d st %h key %h vel %h ticks %0d arg %h off %0d n %0d t %0d",
                   e.kind, e.status, e.key, e.vel, e.ticks, e.arg, e.offset,
                   e.nbytes, e.etime);
          $display("  got kind %0d st %h key %h vel %h ticks %0d arg %h off %0d n %0d t %0d",
                   got.kind, got.status, got.key, got.vel, got.ticks, got.arg,
                   got.offset, got.nbytes, got.etime);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  in_byte = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [3:0]  event_kind;
  logic [7:0]  status_code;
  logic [7:0]  note_key;
  logic [6:0]  note_velocity;
  logic [25:0] ticks;
  logic [7:0]  arg_value;
  logic [31:0] event_offset;
  logic [2:0]  event_bytes;
  logic [31:0] event_time;

  event_scoreboard sb = new();
  int burst_left = 0;
  int bytes_sent = 0;

  music_sequence_event_decoder DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Offer one byte; returns after the transaction completes
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0 && in_valid) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // One well-formed random event, never the end opcode
  task automatic send_random_event();
    logic [7:0] op;
    logic [7:0] flag;
    logic [3:0] kind;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        flag = 8'($urandom);
        send_byte(8'($urandom_range(0, 127)));
        send_byte(flag);
        for (int i = 0; i < flag[7:6]; i++) send_byte(8'($urandom));
      end
      5, 6: send_byte(8'($urandom_range(8'h80, 8'h8F)));
      default: begin
        do op = 8'($urandom_range(8'h90, 8'hFF)); while (op == OP_END);
        send_byte(op);
        n = opcode_args(op, kind);
        for (int i = 0; i < n; i++) send_byte(8'($urandom));
      end
    endcase
  endtask

  // Stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // notes: no duration, 1..2 duration bytes, octave shifts both ways
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h7F); send_byte(8'h7F);
    send_byte(8'h40); send_byte(8'hBF); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h11); send_byte(8'h45); send_byte(8'h80);
    send_byte(8'h22); send_byte(8'h8C); send_byte(8'h01); send_byte(8'h00);
    // short waits, table ends
    send_byte(WAIT_SHORT); send_byte(8'h8F);
    // repeat wait, wait with delta down to saturation and up
    send_byte(OP_WAIT_REP);
    send_byte(OP_WAIT_DELTA); send_byte(8'h80);
    send_byte(OP_WAIT_DELTA); send_byte(8'h7F);
    send_byte(OP_WAIT8); send_byte(8'hFF);
    send_byte(OP_WAIT16); send_byte(8'h34); send_byte(8'h12);
    send_byte(OP_WAIT24); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(OP_WAIT_DELTA); send_byte(8'h7F);
    send_byte(OP_WAIT_REP);
    // octave set and add with wrap
    send_byte(OP_OCT_SET); send_byte(8'hFF);
    send_byte(8'h30); send_byte(8'h3F);
    send_byte(OP_OCT_ADD); send_byte(8'h85);
    // scale to zero, max, back to unity
    send_byte(OP_SCALE); send_byte(8'h00);
    send_byte(8'h10); send_byte(8'hC0); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(OP_SCALE); send_byte(8'hFF);
    send_byte(8'h10); send_byte(8'h20);
    send_byte(OP_SCALE); send_byte(8'h7F);
    // argument events, skips, fadeout, unassigned
    send_byte(OP_TEMPO); send_byte(8'hFF);
    send_byte(OP_PROGRAM); send_byte(8'h00);
    send_byte(OP_VOLUME); send_byte(8'h7F);
    send_byte(OP_EXPR); send_byte(8'h80);
    send_byte(OP_PAN); send_byte(8'h40);
    send_byte(OP_FADE); send_byte(8'h98);
    send_byte(OP_SKIP5);
    for (int i = 0; i < 5; i++) send_byte(8'hAA);
    send_byte(OP_SKIP0);
    send_byte(OP_UNDEF);
    // random part
    while (bytes_sent < 690) send_random_event();
    // end of track, then bytes that must be ignored
    send_byte(OP_END);
    for (int i = 0; i < 8; i++) send_byte(8'($urandom));
    in_valid <= 0;
    wait (sb.pending_events.size() == 0);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: long hold-off once, then alternating stall patterns
  initial begin
    int stretch;
    repeat (7) @(posedge clk);
    repeat (150) @(posedge clk) out_ready <= $urandom_range(0, 3) != 0;
    out_ready <= 0;
    repeat (300) @(posedge clk);
    forever begin
      stretch = $urandom_range(0, 2);
      repeat ($urandom_range(20, 120)) begin
        @(posedge clk);
        case (stretch)
          0: out_ready <= 1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= $urandom_range(0, 7) == 0;
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    event_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = event_kind; got.status = status_code; got.key = note_key;
      got.vel = note_velocity; got.ticks = ticks; got.arg = arg_value;
      got.offset = event_offset; got.nbytes = event_bytes; got.etime = event_time;
      sb.check_event(got);
    end
  end

  // Watchdog
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mused_pkg.sv
hw/rtl/mused_front.sv
hw/rtl/mused_queue.sv
hw/rtl/mused_back.sv
hw/rtl/music_sequence_event_decoder.sv
sim/music_sequence_event_decoder_tb.sv
